/* hdl/bdts_pkg.sv */
package bdts_pkg;

    // Token classes
    localparam logic [2:0] CLS_DEFAULT = 3'd0;
    localparam logic [2:0] CLS_COMMENT = 3'd1;
    localparam logic [2:0] CLS_STRING  = 3'd2;
    localparam logic [2:0] CLS_NUMBER  = 3'd3;
    localparam logic [2:0] CLS_IDENT   = 3'd4;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;

    // Result queue between scanner and output stage
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [3:0] {
        MODE_IDLE      = 4'd0,
        MODE_COMMENT   = 4'd1,
        MODE_STRING    = 4'd2,
        MODE_STR_QUOTE = 4'd3,
        MODE_DOLLAR    = 4'd4,
        MODE_HEX       = 4'd5,
        MODE_INT       = 4'd6,
        MODE_INT_POINT = 4'd7,
        MODE_POINT     = 4'd8,
        MODE_FRAC      = 4'd9,
        MODE_IDENT     = 4'd10
    } mode_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } in_t;

    typedef struct packed {
        logic [9:0]  token_start;
        logic [10:0] token_length;
        logic [2:0]  token_class;
        logic        line_done;
    } out_t;

    // Up to three results of one character, with their count (1..3)
    typedef struct packed {
        out_t [2:0] res;
        logic [1:0] cnt;
    } bundle_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

/* hdl/bdts_front.sv */
module bdts_front #(
    parameter int MAX_LINE = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  acc,
    input  bdts_pkg::in_t         in_item,
    output logic                  push,
    output bdts_pkg::bundle_t     bundle
);

    localparam int CW = $clog2(MAX_LINE);
    localparam int LW = CW + 1;
    localparam logic [CW-1:0] COL_MAX = CW'(MAX_LINE - 1);

    bdts_pkg::mode_t mode_reg, mode_next;
    logic [CW-1:0]   column_reg, column_next;
    logic [CW-1:0]   begin_reg, begin_next;
    logic [CW-1:0]   point_reg, point_next;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == bdts_pkg::CH_UNDER);
    endfunction

    function automatic bdts_pkg::out_t mk(input logic [CW-1:0] st, input logic [LW-1:0] len,
                                          input logic [2:0] cls);
        bdts_pkg::out_t r;
        r.token_start  = 10'(st);
        r.token_length = 11'(len);
        r.token_class  = cls;
        r.line_done    = 1'b0;
        return r;
    endfunction

    // Length of the open token ending just before column e
    function automatic logic [LW-1:0] len_before(input logic [CW-1:0] e,
                                                 input logic [CW-1:0] b);
        logic [LW-1:0] d;
        d = LW'(e) - LW'(b);
        return (e > b) ? d : LW'(1);
    endfunction

    // Length of the open token including column e
    function automatic logic [LW-1:0] len_incl(input logic [CW-1:0] e,
                                               input logic [CW-1:0] b);
        logic [LW-1:0] d;
        d = LW'(e) - LW'(b) + LW'(1);
        return (e >= b) ? d : LW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= bdts_pkg::MODE_IDLE;
            column_reg <= '0;
            begin_reg  <= '0;
            point_reg  <= '0;
        end else if (acc) begin
            mode_reg   <= mode_next;
            column_reg <= column_next;
            begin_reg  <= begin_next;
            point_reg  <= point_next;
        end
    end

    logic [7:0]    c;
    logic [2:0]    n;
    logic          do_start;
    logic [1:0]    last_idx;
    logic [CW-1:0] after_col;

    always_comb begin
        c           = in_item.char_code;
        mode_next   = mode_reg;
        begin_next  = begin_reg;
        point_next  = point_reg;
        bundle      = '0;
        n           = 3'd0;
        do_start    = 1'b0;
        last_idx    = 2'd0;
        after_col   = (column_reg < COL_MAX) ? column_reg + CW'(1) : column_reg;

        // Advance the open token by one character
        case (mode_reg)
            bdts_pkg::MODE_COMMENT: begin
            end
            bdts_pkg::MODE_STRING: begin
                if (c == bdts_pkg::CH_QUOTE) mode_next = bdts_pkg::MODE_STR_QUOTE;
            end
            bdts_pkg::MODE_STR_QUOTE: begin
                if (c == bdts_pkg::CH_QUOTE) begin
                    mode_next = bdts_pkg::MODE_STRING;
                end else begin
                    bundle.res[n[1:0]] = mk(begin_reg, len_before(column_reg, begin_reg),
                                            bdts_pkg::CLS_STRING);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            bdts_pkg::MODE_DOLLAR: begin
                if (is_hex(c)) begin
                    mode_next = bdts_pkg::MODE_HEX;
                end else begin
                    bundle.res[n[1:0]] = mk(begin_reg, LW'(1), bdts_pkg::CLS_DEFAULT);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            bdts_pkg::MODE_HEX: begin
                if (!is_hex(c)) begin
                    bundle.res[n[1:0]] = mk(begin_reg, len_before(column_reg, begin_reg),
                                            bdts_pkg::CLS_NUMBER);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            bdts_pkg::MODE_INT: begin
                if (c == bdts_pkg::CH_POINT) begin
                    point_next = column_reg;
                    mode_next  = bdts_pkg::MODE_INT_POINT;
                end else if (!is_digit(c)) begin
                    bundle.res[n[1:0]] = mk(begin_reg, len_before(column_reg, begin_reg),
                                            bdts_pkg::CLS_NUMBER);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            bdts_pkg::MODE_INT_POINT: begin
                if (is_digit(c)) begin
                    mode_next = bdts_pkg::MODE_FRAC;
                end else begin
                    bundle.res[n[1:0]] = mk(begin_reg, len_before(point_reg, begin_reg),
                                            bdts_pkg::CLS_NUMBER);
                    n = n + 3'd1;
                    bundle.res[n[1:0]] = mk(point_reg, LW'(1), bdts_pkg::CLS_DEFAULT);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            bdts_pkg::MODE_POINT: begin
                if (is_digit(c)) begin
                    mode_next = bdts_pkg::MODE_FRAC;
                end else begin
                    bundle.res[n[1:0]] = mk(begin_reg, LW'(1), bdts_pkg::CLS_DEFAULT);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            bdts_pkg::MODE_FRAC: begin
                if (!is_digit(c)) begin
                    bundle.res[n[1:0]] = mk(begin_reg, len_before(column_reg, begin_reg),
                                            bdts_pkg::CLS_NUMBER);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            bdts_pkg::MODE_IDENT: begin
                if (is_word(c)) begin
                end else if ((c == bdts_pkg::CH_DOLLAR) || (c == bdts_pkg::CH_HASH) ||
                             (c == bdts_pkg::CH_PERCENT)) begin
                    bundle.res[n[1:0]] = mk(begin_reg, len_incl(column_reg, begin_reg),
                                            bdts_pkg::CLS_IDENT);
                    n = n + 3'd1;
                    mode_next = bdts_pkg::MODE_IDLE;
                end else begin
                    bundle.res[n[1:0]] = mk(begin_reg, len_before(column_reg, begin_reg),
                                            bdts_pkg::CLS_IDENT);
                    n = n + 3'd1;
                    do_start = 1'b1;
                end
            end
            default: do_start = 1'b1;
        endcase

        // Open a new token at this character
        if (do_start) begin
            begin_next = column_reg;
            if ((c == bdts_pkg::CH_SPACE) || (c == bdts_pkg::CH_TAB)) begin
                mode_next = bdts_pkg::MODE_IDLE;
            end else if (c == bdts_pkg::CH_SEMI) begin
                mode_next = bdts_pkg::MODE_COMMENT;
            end else if (c == bdts_pkg::CH_QUOTE) begin
                mode_next = bdts_pkg::MODE_STRING;
            end else if (c == bdts_pkg::CH_DOLLAR) begin
                mode_next = bdts_pkg::MODE_DOLLAR;
            end else if (is_digit(c)) begin
                mode_next = bdts_pkg::MODE_INT;
            end else if (c == bdts_pkg::CH_POINT) begin
                mode_next = bdts_pkg::MODE_POINT;
            end else if (is_alpha(c) || (c == bdts_pkg::CH_UNDER)) begin
                mode_next = bdts_pkg::MODE_IDENT;
            end else begin
                bundle.res[n[1:0]] = mk(column_reg, LW'(1), bdts_pkg::CLS_DEFAULT);
                n = n + 3'd1;
                mode_next = bdts_pkg::MODE_IDLE;
            end
        end

        if (in_item.line_end) begin
            // Close whatever is still open at line end
            case (mode_next)
                bdts_pkg::MODE_COMMENT: begin
                    bundle.res[n[1:0]] = mk(begin_next, len_incl(column_reg, begin_next),
                                            bdts_pkg::CLS_COMMENT);
                    n = n + 3'd1;
                end
                bdts_pkg::MODE_STRING, bdts_pkg::MODE_STR_QUOTE: begin
                    bundle.res[n[1:0]] = mk(begin_next, len_incl(column_reg, begin_next),
                                            bdts_pkg::CLS_STRING);
                    n = n + 3'd1;
                end
                bdts_pkg::MODE_DOLLAR, bdts_pkg::MODE_POINT: begin
                    bundle.res[n[1:0]] = mk(begin_next, LW'(1), bdts_pkg::CLS_DEFAULT);
                    n = n + 3'd1;
                end
                bdts_pkg::MODE_HEX, bdts_pkg::MODE_INT, bdts_pkg::MODE_FRAC: begin
                    bundle.res[n[1:0]] = mk(begin_next, len_incl(column_reg, begin_next),
                                            bdts_pkg::CLS_NUMBER);
                    n = n + 3'd1;
                end
                bdts_pkg::MODE_INT_POINT: begin
                    bundle.res[n[1:0]] = mk(begin_next, len_before(point_next, begin_next),
                                            bdts_pkg::CLS_NUMBER);
                    n = n + 3'd1;
                    bundle.res[n[1:0]] = mk(point_next, LW'(1), bdts_pkg::CLS_DEFAULT);
                    n = n + 3'd1;
                end
                bdts_pkg::MODE_IDENT: begin
                    bundle.res[n[1:0]] = mk(begin_next, len_incl(column_reg, begin_next),
                                            bdts_pkg::CLS_IDENT);
                    n = n + 3'd1;
                end
                default: begin
                end
            endcase
            // Empty line end gets a marker result
            if (n == 3'd0) begin
                bundle.res[0] = mk(after_col, LW'(0), bdts_pkg::CLS_DEFAULT);
                n = 3'd1;
            end
            last_idx = n[1:0] - 2'd1;
            bundle.res[last_idx].line_done = 1'b1;
            mode_next   = bdts_pkg::MODE_IDLE;
            column_next = '0;
        end else begin
            column_next = after_col;
        end

        bundle.cnt = n[1:0];
        push       = acc && (n != 3'd0);
    end

endmodule

/* hdl/bdts_queue.sv */
module bdts_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  bdts_pkg::bundle_t      wr_bundle,
    input  logic                   pop,
    output bdts_pkg::bundle_t      rd_bundle,
    output bdts_pkg::q_status_t    status
);

    localparam int CNTW = $clog2(bdts_pkg::QDEPTH + 1);

    bdts_pkg::bundle_t          mem [bdts_pkg::QDEPTH];
    logic [bdts_pkg::QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bdts_pkg::QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]            count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + bdts_pkg::QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + bdts_pkg::QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + CNTW'(push) - CNTW'(pop);
        rd_bundle    = mem[rd_ptr_reg];
        status.empty = (count_reg == '0);
        status.full  = (count_reg == CNTW'(bdts_pkg::QDEPTH));
    end

endmodule

/* hdl/bdts_back.sv */
module bdts_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bdts_pkg::bundle_t      head,
    input  bdts_pkg::q_status_t    status,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output bdts_pkg::out_t         m_payload
);

    logic [1:0]      sub_reg, sub_next;
    logic            valid_reg, valid_next;
    bdts_pkg::out_t  data_reg, data_next;
    logic            load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // Load a queued token when the output register is empty or drained
    always_comb begin
        load       = !status.empty && (!valid_reg || m_ready);
        sub_next   = sub_reg;
        data_next  = data_reg;
        valid_next = valid_reg && !m_ready;
        pop        = 1'b0;
        if (load) begin
            data_next  = head.res[sub_reg];
            valid_next = 1'b1;
            if (sub_reg == head.cnt - 2'd1) begin
                pop      = 1'b1;
                sub_next = '0;
            end else begin
                sub_next = sub_reg + 2'd1;
            end
        end
    end

    assign m_valid   = valid_reg;
    assign m_payload = data_reg;

endmodule

/* hdl/basic_dialect_token_scanner_unit.sv */
// Channel   Dir  Handshake          Payload
// s_        in   s_valid / s_ready  bdts_pkg::in_t  (char_code, line_end)
// m_        out  m_valid / m_ready  bdts_pkg::out_t (token_start, token_length,
//                                                    token_class, line_done)
// One character is accepted per cycle while the result queue has room.
// Each character yields zero to three tokens; they leave one per cycle while
// m_ready is high, through the queue and then a registered output stage.
// The four-entry queue between the scanner and the output stage sets how
// far a stalled m_ready is absorbed before s_ready drops.
// aresetn is synchronous, active low; it clears the scanner, the queue and the output stage.
module basic_dialect_token_scanner_unit #(
    parameter int MAX_LINE = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bdts_pkg::in_t    s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output bdts_pkg::out_t   m_payload
);

    logic                 acc;
    logic                 push;
    logic                 pop;
    bdts_pkg::bundle_t    wr_bundle;
    bdts_pkg::bundle_t    head;
    bdts_pkg::q_status_t  q_status;

    // Take a request whenever the queue can hold its tokens
    assign s_ready = !q_status.full;
    assign acc     = s_valid && s_ready;

    // Front: classify characters and close tokens
    bdts_front #(
        .MAX_LINE(MAX_LINE)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .acc     (acc),
        .in_item (s_payload),
        .push    (push),
        .bundle  (wr_bundle)
    );

    // Hold token groups while the output side stalls
    bdts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_bundle (wr_bundle),
        .pop       (pop),
        .rd_bundle (head),
        .status    (q_status)
    );

    // Back: hand out one token per cycle while m_ready is high
    bdts_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .status    (q_status),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

/* tb/sv/tok_track_pkg.sv */
`timescale 1ns / 100ps

package tok_track_pkg;
    import bdts_pkg::*;

    localparam int unsigned LINE_COLS = 1024;

    class token_tracker;
        mode_t       mode;
        logic [9:0]  col;
        logic [9:0]  tok_begin;
        logic [9:0]  point_col;
        out_t        step_tokens[$];
        out_t        tokens_due[$];
        int unsigned errors;
        int unsigned chars_seen;
        int unsigned lines_seen;
        int unsigned tokens_checked;
        int unsigned class_count[5];

        function new();
            mode = MODE_IDLE;
            col = '0;
            tok_begin = '0;
            point_col = '0;
            errors = 0;
            chars_seen = 0;
            lines_seen = 0;
            tokens_checked = 0;
            foreach (class_count[i]) class_count[i] = 0;
        endfunction

        static function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        static function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        static function bit is_hex(logic [7:0] c);
            return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        static function bit is_word(logic [7:0] c);
            return is_alpha(c) || is_digit(c) || c == CH_UNDER;
        endfunction

        // Keep at most three tokens per character.
        function void add_token(logic [9:0] start, logic [10:0] len, logic [2:0] cls);
            out_t t;
            if (step_tokens.size() >= 3) return;
            t.token_start  = start;
            t.token_length = len;
            t.token_class  = cls;
            t.line_done    = 1'b0;
            step_tokens.push_back(t);
        endfunction

        // Length of the open token ending just before column stop.
        function logic [10:0] len_before(logic [9:0] stop);
            logic [10:0] n;
            n = (stop > tok_begin) ? 11'(stop - tok_begin) : 11'd0;
            return (n == 11'd0) ? 11'd1 : n;
        endfunction

        // Length of the open token including the current column.
        function logic [10:0] len_incl();
            return ((col >= tok_begin) ? 11'(col - tok_begin) : 11'd0) + 11'd1;
        endfunction

        function void start_token(logic [7:0] c);
            tok_begin = col;
            if (c == CH_SPACE || c == CH_TAB) mode = MODE_IDLE;
            else if (c == CH_SEMI) mode = MODE_COMMENT;
            else if (c == CH_QUOTE) mode = MODE_STRING;
            else if (c == CH_DOLLAR) mode = MODE_DOLLAR;
            else if (is_digit(c)) mode = MODE_INT;
            else if (c == CH_POINT) mode = MODE_POINT;
            else if (is_alpha(c) || c == CH_UNDER) mode = MODE_IDENT;
            else begin
                add_token(col, 11'd1, CLS_DEFAULT);
                mode = MODE_IDLE;
            end
        endfunction

        // Advance the scanner by one accepted character; queue its tokens.
        function void take_char(in_t req);
            logic [7:0] c;
            logic [9:0] after;
            out_t       t;
            c = req.char_code;
            step_tokens.delete();
            chars_seen++;
            case (mode)
                MODE_COMMENT: ;
                MODE_STRING: begin
                    if (c == CH_QUOTE) mode = MODE_STR_QUOTE;
                end
                MODE_STR_QUOTE: begin
                    if (c == CH_QUOTE) mode = MODE_STRING;
                    else begin
                        add_token(tok_begin, len_before(col), CLS_STRING);
                        start_token(c);
                    end
                end
                MODE_DOLLAR: begin
                    if (is_hex(c)) mode = MODE_HEX;
                    else begin
                        add_token(tok_begin, 11'd1, CLS_DEFAULT);
                        start_token(c);
                    end
                end
                MODE_HEX: begin
                    if (!is_hex(c)) begin
                        add_token(tok_begin, len_before(col), CLS_NUMBER);
                        start_token(c);
                    end
                end
                MODE_INT: begin
                    if (c == CH_POINT) begin
                        point_col = col;
                        mode = MODE_INT_POINT;
                    end else if (!is_digit(c)) begin
                        add_token(tok_begin, len_before(col), CLS_NUMBER);
                        start_token(c);
                    end
                end
                MODE_INT_POINT: begin
                    if (is_digit(c)) mode = MODE_FRAC;
                    else begin
                        add_token(tok_begin, len_before(point_col), CLS_NUMBER);
                        add_token(point_col, 11'd1, CLS_DEFAULT);
                        start_token(c);
                    end
                end
                MODE_POINT: begin
                    if (is_digit(c)) mode = MODE_FRAC;
                    else begin
                        add_token(tok_begin, 11'd1, CLS_DEFAULT);
                        start_token(c);
                    end
                end
                MODE_FRAC: begin
                    if (!is_digit(c)) begin
                        add_token(tok_begin, len_before(col), CLS_NUMBER);
                        start_token(c);
                    end
                end
                MODE_IDENT: begin
                    if (is_word(c)) ;
                    else if (c == CH_DOLLAR || c == CH_HASH || c == CH_PERCENT) begin
                        add_token(tok_begin, len_incl(), CLS_IDENT);
                        mode = MODE_IDLE;
                    end else begin
                        add_token(tok_begin, len_before(col), CLS_IDENT);
                        start_token(c);
                    end
                end
                default: start_token(c);
            endcase

            if (req.line_end) begin
                // Close whatever is still open at the end of the line.
                case (mode)
                    MODE_COMMENT: add_token(tok_begin, len_incl(), CLS_COMMENT);
                    MODE_STRING, MODE_STR_QUOTE: add_token(tok_begin, len_incl(), CLS_STRING);
                    MODE_DOLLAR, MODE_POINT: add_token(tok_begin, 11'd1, CLS_DEFAULT);
                    MODE_HEX, MODE_INT, MODE_FRAC:
                        add_token(tok_begin, len_incl(), CLS_NUMBER);
                    MODE_INT_POINT: begin
                        add_token(tok_begin, len_before(point_col), CLS_NUMBER);
                        add_token(point_col, 11'd1, CLS_DEFAULT);
                    end
                    MODE_IDENT: add_token(tok_begin, len_incl(), CLS_IDENT);
                    default: ;
                endcase
                if (step_tokens.size() == 0) begin
                    after = (col < LINE_COLS - 1) ? 10'(col + 10'd1) : col;
                    add_token(after, 11'd0, CLS_DEFAULT);
                end
                t = step_tokens.pop_back();
                t.line_done = 1'b1;
                step_tokens.push_back(t);
                mode = MODE_IDLE;
                col = '0;
                lines_seen++;
            end else if (col < LINE_COLS - 1) begin
                col++;
            end

            foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
        endfunction

        // Compare one delivered token against the oldest one due.
        function void match_token(out_t got);
            out_t want;
            if (tokens_due.size() == 0) begin
                $error("unexpected token: start %0d length %0d class %0d done %0d",
                       got.token_start, got.token_length, got.token_class, got.line_done);
                errors++;
                return;
            end
            want = tokens_due.pop_front();
            tokens_checked++;
            if (got.token_class <= CLS_IDENT) class_count[got.token_class]++;
            if (got.token_start !== want.token_start) begin
                $error("token_start: expected %0d, got %0d", want.token_start, got.token_start);
                errors++;
            end
            if (got.token_length !== want.token_length) begin
                $error("token_length: expected %0d, got %0d",
                       want.token_length, got.token_length);
                errors++;
            end
            if (got.token_class !== want.token_class) begin
                $error("token_class: expected %0d, got %0d", want.token_class, got.token_class);
                errors++;
            end
            if (got.line_done !== want.line_done) begin
                $error("line_done: expected %0d, got %0d", want.line_done, got.line_done);
                errors++;
            end
        endfunction
    endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import bdts_pkg::*;
    import tok_track_pkg::*;

    // Cycles with no handshake on either side before the run is declared hung.
    localparam int STALL_LIMIT     = 4000;
    // Extra cycles after the last token, enough for the two-stage output path.
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 68;

    // Character sets for building lines.
    localparam string IDENT_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string WORD_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    localparam string DIGITS     = "0123456789";
    localparam string HEX_CHARS  = "0123456789abcdefABCDEF";
    localparam string SUFFIXES   = "$#%";
    localparam string PUNCT      = "=+-*/()<>,:#%'!&?@[]^`{|}~\\";
    localparam string BLANKS     = " \t";
    localparam string TEXT_CHARS = "abcXYZ019 ;.$#_";

    logic aclk      = 1'b0;
    logic aresetn   = 1'b0;
    logic s_valid   = 1'b0;
    logic s_ready;
    in_t  s_payload = '0;
    logic m_valid;
    logic m_ready   = 1'b0;
    out_t m_payload;

    // Pacing knobs in percent of cycles, then the watchdog and phase counters.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned phase_items    = 0;

    token_tracker tracker;

    basic_dialect_token_scanner_unit #(
        .MAX_LINE(LINE_COLS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Receiver: stall at random, one decision per falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: sample both channels at the rising edge, before the block updates.
    // Also run the watchdog on cycles where nothing moves.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) tracker.take_char(s_payload);
            if (m_valid && m_ready) tracker.match_token(m_payload);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    function automatic logic [7:0] pick(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // Append one token-shaped fragment; noise and punctuation break sequences up.
    function automatic void add_fragment(ref logic [7:0] q[$]);
        case ($urandom_range(0, 9))
            0, 1: begin
                q.push_back(pick(IDENT_HEAD));
                repeat ($urandom_range(0, 6)) q.push_back(pick(WORD_CHARS));
                if ($urandom_range(0, 2) == 0) q.push_back(pick(SUFFIXES));
            end
            2, 3: begin
                repeat ($urandom_range(1, 4)) q.push_back(pick(DIGITS));
                case ($urandom_range(0, 2))
                    1: begin
                        q.push_back(CH_POINT);
                        repeat ($urandom_range(1, 3)) q.push_back(pick(DIGITS));
                    end
                    2: q.push_back(CH_POINT);   // trailing point
                    default: ;
                endcase
            end
            4: begin
                // Leading point; no digits leaves a lone point.
                q.push_back(CH_POINT);
                repeat ($urandom_range(0, 3)) q.push_back(pick(DIGITS));
            end
            5: begin
                // Hex number; no digits leaves a lone dollar.
                q.push_back(CH_DOLLAR);
                repeat ($urandom_range(0, 4)) q.push_back(pick(HEX_CHARS));
            end
            6: begin
                q.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        q.push_back(CH_QUOTE);
                        q.push_back(CH_QUOTE);
                    end else begin
                        q.push_back(pick(TEXT_CHARS));
                    end
                end
                // Leave some strings open to the end of the line.
                if ($urandom_range(0, 9) < 7) q.push_back(CH_QUOTE);
            end
            7: q.push_back(pick(PUNCT));
            8: q.push_back(8'($urandom_range(0, 255)));
            default: repeat ($urandom_range(1, 2)) q.push_back(pick(BLANKS));
        endcase
    endfunction

    // Build a line of fragments, at least min_len characters long.
    function automatic void build_line(ref logic [7:0] q[$], input int min_len);
        int pieces;
        q.delete();
        pieces = $urandom_range(0, 6);
        for (int i = 0; i < pieces || q.size() < min_len; i++) begin
            add_fragment(q);
            if ($urandom_range(0, 1)) q.push_back(pick(BLANKS));
        end
        if (min_len == 0 && $urandom_range(0, 4) == 0) begin
            q.push_back(CH_SEMI);
            repeat ($urandom_range(0, 8)) q.push_back(pick(TEXT_CHARS));
        end
        // An empty line still needs one character to carry the line end.
        if (q.size() == 0) q.push_back(pick(BLANKS));
    endfunction

    // Drive one request at the falling edge and hold it until the scanner
    // takes it. Return right after the accepting rising edge.
    task automatic send_char(input logic [7:0] c, input logic last);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= '{char_code: c, line_end: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        phase_items++;
    endtask

    task automatic send_bytes(input logic [7:0] q[$]);
        foreach (q[i]) send_char(q[i], i == q.size() - 1);
    endtask

    task automatic send_text(input string s);
        logic [7:0] q[$];
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        send_bytes(q);
    endtask

    // Drop valid and hold off until every token due has been delivered.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.tokens_due.size() != 0) @(negedge aclk);
    endtask

    initial begin
        logic [7:0]  line[$];
        int unsigned send_pct[4];
        int unsigned stall_pct[4];
        send_pct  = '{0, 55, 0, 26};
        stall_pct = '{0, 0, 55, 26};
        tracker = new();

        // Hold reset low, then release it at a falling edge.
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed lines, no idling.
        send_text("x$=3.");          // suffixed identifier, default, trailing point at end
        send_text("$F.5\t$");        // hex, point then digits, tab, lone dollar at end
        send_text("\"\"\"\"9;");     // doubled quote in a string, number, comment at end
        send_text("\"z");            // string left open at the end
        send_text(" ");              // line end without a token
        line = {8'hFF};
        send_bytes(line);            // high code as a default token
        line = {8'h00};
        send_bytes(line);
        send_text("_a.");            // identifier then lone point at end
        send_text("1.x");            // trailing point in mid-line
        wait_drained();

        // Random lines under four pacing phases; drain fully between phases.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = stall_pct[p];
            phase_items    = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                build_line(line, 0);
                send_bytes(line);
            end
            wait_drained();
        end

        // Let any stray token surface before the final verdict.
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (tracker.tokens_due.size() != 0) begin
            $error("%0d expected tokens never arrived", tracker.tokens_due.size());
            tracker.errors++;
        end

        $display("Scanned %0d characters in %0d lines; %0d tokens compared", tracker.chars_seen,
                 tracker.lines_seen, tracker.tokens_checked);
        $display("  default %0d, comment %0d, string %0d, number %0d, identifier %0d",
                 tracker.class_count[CLS_DEFAULT], tracker.class_count[CLS_COMMENT],
                 tracker.class_count[CLS_STRING], tracker.class_count[CLS_NUMBER],
                 tracker.class_count[CLS_IDENT]);
        if (tracker.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

/* basic_dialect_token_scanner_unit.f */
hdl/bdts_pkg.sv
hdl/bdts_front.sv
hdl/bdts_queue.sv
hdl/bdts_back.sv
hdl/basic_dialect_token_scanner_unit.sv
tb/sv/tok_track_pkg.sv
tb/sv/tb_top.sv
